>>> hw/rtl/pfb_pkg.sv
// Shared constants, types and transform functions for the packet field buffer codec.
package pfb_pkg;

  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int CUR_W     = $clog2(BUF_BYTES + 1);
  localparam int SUM_W     = CUR_W + 1;
  localparam int MAX_WIN   = 64;
  localparam int WIN_W     = 7;
  localparam int CNT_W     = 6;

  localparam int MOD_NEG = 0;
  localparam int MOD_INV = 1;
  localparam int MOD_OFS = 2;
  localparam int MOD_LE  = 3;
  localparam int MOD_NL  = 4;

  localparam logic [7:0] TERM_NUL = 8'd0;
  localparam logic [7:0] TERM_NL  = 8'd10;
  localparam logic [7:0] OFS_VAL  = 8'd128;

  typedef enum logic [1:0] {
    REQ_PUT  = 2'd0,
    REQ_GET  = 2'd1,
    REQ_SEEK = 2'd2,
    REQ_STR  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_END    = 2'd1,
    STAT_NOTERM = 2'd2
  } status_t;

  function automatic logic [3:0] width_bytes(input logic [2:0] code);
    logic [3:0] n;
    unique case (code)
      3'd0:    n = 4'd1;
      3'd1:    n = 4'd2;
      3'd2:    n = 4'd3;
      3'd3:    n = 4'd4;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] lsb_xform(input logic [7:0] b, input logic [4:0] mods,
                                            input logic is_put);
    logic [7:0] r;
    r = b;
    if (mods[MOD_NEG]) r = 8'd0 - r;
    if (mods[MOD_INV]) r = OFS_VAL - r;
    if (mods[MOD_OFS]) r = is_put ? (r + OFS_VAL) : (r - OFS_VAL);
    return r;
  endfunction

endpackage

>>> hw/rtl/pfb_ram.sv
// Single-port synchronous byte store with a registered read.
module pfb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/packet_field_buffer_codec.sv
// Top level: request sequencer around the byte store of the packet field buffer codec.
// A put or get makes one store access per byte of the field; a seek makes none. A
// get-string scans one byte per cycle for the terminator, within the window (capped
// at 64 bytes), and then gives the string one byte per cycle.
// After reset the store is swept to zero, one byte per cycle, with busy high.
// Results are one-cycle strobes; the receiver cannot stall them.
module packet_field_buffer_codec
  import pfb_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       req_type,
  input  logic [2:0]       width_code,
  input  logic [63:0]      put_value,
  input  logic [4:0]       modifiers,
  input  logic [CUR_W-1:0] seek_target,
  input  logic [WIN_W-1:0] max_len,
  output logic             strobe,
  output logic [63:0]      value_out,
  output logic [1:0]       status,
  output logic [CUR_W-1:0] cursor_now,
  output logic [CNT_W-1:0] string_count,
  output logic             last
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUT,
    S_GET,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t            state;
  logic [CUR_W-1:0]  cursor;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] base;
  logic [WIN_W-1:0]  idx;
  logic [WIN_W-1:0]  rd_idx;
  logic              rd_pend;
  logic [3:0]        nbytes;
  logic [4:0]        mods;
  logic [63:0]       word;
  logic [WIN_W-1:0]  win_last;
  logic [7:0]        term;
  logic [CNT_W-1:0]  slen;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  logic [2:0]        put_sh;
  logic [2:0]        get_sh;
  logic [63:0]       asm_word;
  logic [WIN_W-1:0]  win;
  logic [3:0]        req_n;
  logic [SUM_W-1:0]  field_end;
  logic [SUM_W-1:0]  win_end;

  pfb_ram #(.DEPTH(BUF_BYTES), .WIDTH(8)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    req_n     = width_bytes(width_code);
    win       = (max_len > WIN_W'(MAX_WIN)) ? WIN_W'(MAX_WIN) : max_len;
    field_end = SUM_W'(cursor) + SUM_W'(req_n);
    win_end   = SUM_W'(cursor) + SUM_W'(win);
    put_sh    = mods[MOD_LE] ? idx[2:0] : 3'(nbytes - 4'd1 - idx[3:0]);
    get_sh    = mods[MOD_LE] ? rd_idx[2:0] : 3'(nbytes - 4'd1 - rd_idx[3:0]);
    asm_word  = word;
    if (rd_pend) begin
      asm_word[{get_sh, 3'b000} +: 8] = ram_rdata;
    end
    ram_we    = 1'b0;
    ram_addr  = base + ADDR_W'(idx);
    ram_wdata = word[{put_sh, 3'b000} +: 8];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = 8'd0;
      end
      S_PUT: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      cursor   <= '0;
      rd_pend  <= 1'b0;
      idx      <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(BUF_BYTES - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (start) begin
            base         <= cursor[ADDR_W-1:0];
            mods         <= modifiers;
            nbytes       <= req_n;
            idx          <= '0;
            rd_pend      <= 1'b0;
            term         <= modifiers[MOD_NL] ? TERM_NL : TERM_NUL;
            value_out    <= '0;
            string_count <= '0;
            last         <= 1'b1;
            cursor_now   <= cursor;
            status       <= STAT_OK;
            unique case (req_t'(req_type))
              REQ_SEEK: begin
                strobe <= 1'b1;
                if (seek_target > CUR_W'(BUF_BYTES)) begin
                  status <= STAT_END;
                end else begin
                  cursor     <= seek_target;
                  cursor_now <= seek_target;
                end
              end
              REQ_PUT, REQ_GET: begin
                if (field_end > SUM_W'(BUF_BYTES)) begin
                  strobe <= 1'b1;
                  status <= STAT_END;
                end else if (req_t'(req_type) == REQ_PUT) begin
                  word  <= {put_value[63:8], lsb_xform(put_value[7:0], modifiers, 1'b1)};
                  state <= S_PUT;
                end else begin
                  word  <= '0;
                  state <= S_GET;
                end
              end
              REQ_STR: begin
                if (win_end > SUM_W'(BUF_BYTES)) begin
                  strobe <= 1'b1;
                  status <= STAT_END;
                end else if (win <= WIN_W'(1)) begin
                  strobe <= 1'b1;
                  status <= STAT_NOTERM;
                end else begin
                  win_last <= win - 1'b1;
                  state    <= S_SCAN;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_PUT: begin
          idx <= idx + 1'b1;
          if (idx == WIN_W'(nbytes - 4'd1)) begin
            cursor       <= cursor + CUR_W'(nbytes);
            strobe       <= 1'b1;
            value_out    <= '0;
            status       <= STAT_OK;
            cursor_now   <= cursor + CUR_W'(nbytes);
            string_count <= '0;
            last         <= 1'b1;
            state        <= S_IDLE;
          end
        end

        S_GET: begin
          rd_pend <= (idx < WIN_W'(nbytes));
          rd_idx  <= idx;
          if (idx < WIN_W'(nbytes)) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend) begin
            word <= asm_word;
            if (rd_idx == WIN_W'(nbytes - 4'd1)) begin
              cursor       <= cursor + CUR_W'(nbytes);
              strobe       <= 1'b1;
              value_out    <= {asm_word[63:8], lsb_xform(asm_word[7:0], mods, 1'b0)};
              status       <= STAT_OK;
              cursor_now   <= cursor + CUR_W'(nbytes);
              string_count <= '0;
              last         <= 1'b1;
              rd_pend      <= 1'b0;
              state        <= S_IDLE;
            end
          end
        end

        S_SCAN: begin
          rd_pend <= (idx < win_last);
          rd_idx  <= idx;
          if (idx < win_last) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend) begin
            if (ram_rdata == term) begin
              cursor  <= cursor + CUR_W'(rd_idx) + 1'b1;
              slen    <= rd_idx[CNT_W-1:0];
              rd_pend <= 1'b0;
              idx     <= '0;
              if (rd_idx == '0) begin
                strobe       <= 1'b1;
                value_out    <= '0;
                status       <= STAT_OK;
                cursor_now   <= cursor + 1'b1;
                string_count <= '0;
                last         <= 1'b1;
                state        <= S_IDLE;
              end else begin
                state <= S_EMIT;
              end
            end else if (rd_idx == win_last - 1'b1) begin
              strobe       <= 1'b1;
              value_out    <= '0;
              status       <= STAT_NOTERM;
              cursor_now   <= cursor;
              string_count <= '0;
              last         <= 1'b1;
              rd_pend      <= 1'b0;
              state        <= S_IDLE;
            end
          end
        end

        S_EMIT: begin
          rd_pend <= (idx < WIN_W'(slen));
          rd_idx  <= idx;
          if (idx < WIN_W'(slen)) begin
            idx <= idx + 1'b1;
          end
          if (rd_pend) begin
            strobe     <= 1'b1;
            value_out  <= {56'd0, ram_rdata};
            status     <= STAT_OK;
            cursor_now <= cursor;
            if (rd_idx == WIN_W'(slen) - 1'b1) begin
              string_count <= slen;
              last         <= 1'b1;
              rd_pend      <= 1'b0;
              state        <= S_IDLE;
            end else begin
              string_count <= '0;
              last         <= 1'b0;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> tb/sv/codec_scoreboard_pkg.sv
// Scoreboard class that predicts and checks the results of the packet field buffer codec.
package codec_scoreboard_pkg;
  import pfb_pkg::*;

  typedef struct {
    logic [63:0]      value;
    status_t          st;
    logic [CUR_W-1:0] cur;
    logic [CNT_W-1:0] count;
    logic             fin;
  } codec_result_t;

  class field_buffer_scoreboard;
    logic [7:0]    image [BUF_BYTES];
    int unsigned   pos;
    codec_result_t pending_q [$];
    int            mismatches;
    int            results_seen;
    int            strings_found;
    int            req_seen [4];

    function new();
      foreach (image[i]) image[i] = 8'h00;
      foreach (req_seen[i]) req_seen[i] = 0;
      pos = 0;
      mismatches = 0;
      results_seen = 0;
      strings_found = 0;
    endfunction

    function int outstanding();
      return pending_q.size();
    endfunction

    task report(string msg);
      if (mismatches < 40) $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Adding or subtracting 128 in eight bits both amount to flipping the top bit.
    function logic [7:0] adjust_low(logic [7:0] b, logic [4:0] mods);
      logic [7:0] r;
      r = b;
      if (mods[MOD_NEG]) r = ~r + 8'd1;
      if (mods[MOD_INV]) r = 8'h80 - r;
      if (mods[MOD_OFS]) r = r ^ 8'h80;
      return r;
    endfunction

    function void queue_result(logic [63:0] v, status_t st, int unsigned count, bit fin);
      codec_result_t r;
      r.value = v;
      r.st    = st;
      r.cur   = pos[CUR_W-1:0];
      r.count = count[CNT_W-1:0];
      r.fin   = fin;
      pending_q.push_back(r);
    endfunction

    function void note_request(req_t rq, logic [2:0] wc, logic [63:0] pv, logic [4:0] mods,
                               logic [CUR_W-1:0] tgt, logic [WIN_W-1:0] ml);
      int unsigned n, win, len, sh, k, base;
      logic [63:0] v;
      logic [7:0]  term;
      bit          found;
      req_seen[int'(rq)]++;
      n = (wc < 3'd4) ? int'(wc) + 1 : 8;
      case (rq)
        REQ_SEEK: begin
          if (tgt > BUF_BYTES) begin
            queue_result(64'd0, STAT_END, 0, 1'b1);
          end else begin
            pos = tgt;
            queue_result(64'd0, STAT_OK, 0, 1'b1);
          end
        end
        REQ_PUT, REQ_GET: begin
          if (pos + n > BUF_BYTES) begin
            queue_result(64'd0, STAT_END, 0, 1'b1);
          end else if (rq == REQ_PUT) begin
            v = pv;
            v[7:0] = adjust_low(pv[7:0], mods);
            for (k = 0; k < n; k++) begin
              sh = mods[MOD_LE] ? k : n - 1 - k;
              image[pos + k] = v[8*sh +: 8];
            end
            pos += n;
            queue_result(64'd0, STAT_OK, 0, 1'b1);
          end else begin
            v = '0;
            for (k = 0; k < n; k++) begin
              sh = mods[MOD_LE] ? k : n - 1 - k;
              v[8*sh +: 8] = image[pos + k];
            end
            v[7:0] = adjust_low(v[7:0], mods);
            pos += n;
            queue_result(v, STAT_OK, 0, 1'b1);
          end
        end
        default: begin
          win = (ml > MAX_WIN) ? MAX_WIN : ml;
          term = mods[MOD_NL] ? TERM_NL : TERM_NUL;
          found = 1'b0;
          len = 0;
          if (pos + win > BUF_BYTES) begin
            queue_result(64'd0, STAT_END, 0, 1'b1);
          end else begin
            for (k = 0; k + 1 < win && !found; k++) begin
              if (image[pos + k] == term) begin
                found = 1'b1;
                len = k;
              end
            end
            if (!found) begin
              queue_result(64'd0, STAT_NOTERM, 0, 1'b1);
            end else begin
              base = pos;
              pos = base + len + 1;
              strings_found++;
              if (len == 0) begin
                queue_result(64'd0, STAT_OK, 0, 1'b1);
              end else begin
                for (k = 0; k < len; k++)
                  queue_result({56'd0, image[base + k]}, STAT_OK, (k + 1 == len) ? len : 0,
                               k + 1 == len);
              end
            end
          end
        end
      endcase
    endfunction

    task check_result(logic [63:0] v, logic [1:0] st, logic [CUR_W-1:0] cur,
                      logic [CNT_W-1:0] count, logic fin);
      codec_result_t e;
      results_seen++;
      if (pending_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending (value %h status %0d)",
                         results_seen, v, st));
        return;
      end
      e = pending_q.pop_front();
      if (v !== e.value)
        report($sformatf("result %0d value_out %h, predicted %h", results_seen, v, e.value));
      if (st !== e.st)
        report($sformatf("result %0d status %0d, predicted %0d", results_seen, st, e.st));
      if (cur !== e.cur)
        report($sformatf("result %0d cursor_now %0d, predicted %0d", results_seen, cur, e.cur));
      if (count !== e.count)
        report($sformatf("result %0d string_count %0d, predicted %0d", results_seen, count,
                         e.count));
      if (fin !== e.fin)
        report($sformatf("result %0d last %b, predicted %b", results_seen, fin, e.fin));
    endtask
  endclass

endpackage

>>> tb/sv/tb_top.sv
// Top of the packet field buffer codec testbench: clock, reset, stimulus and result monitor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pfb_pkg::*;
  import codec_scoreboard_pkg::*;

  localparam int QUIET_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 325;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       req_type;
  logic [2:0]       width_code;
  logic [63:0]      put_value;
  logic [4:0]       modifiers;
  logic [CUR_W-1:0] seek_target;
  logic [WIN_W-1:0] max_len;
  logic             strobe;
  logic [63:0]      value_out;
  logic [1:0]       status;
  logic [CUR_W-1:0] cursor_now;
  logic [CNT_W-1:0] string_count;
  logic             last;

  field_buffer_scoreboard sb;
  int sent;
  int burst_left;
  int gap_max;
  int quiet;

  packet_field_buffer_codec dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .width_code(width_code), .put_value(put_value),
    .modifiers(modifiers), .seek_target(seek_target), .max_len(max_len),
    .strobe(strobe), .value_out(value_out), .status(status), .cursor_now(cursor_now),
    .string_count(string_count), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet = 0;
    end else begin
      if (strobe) sb.check_result(value_out, status, cursor_now, string_count, last);
      if ((start && !busy) || strobe) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == TERM_NL) b = 8'd11;
    return b;
  endfunction

  function automatic int unsigned pick_base();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 600);
    return $urandom_range(4030, BUF_BYTES);
  endfunction

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic issue(req_t rq, logic [2:0] wc, logic [63:0] pv, logic [4:0] mods,
                       logic [CUR_W-1:0] tgt, logic [WIN_W-1:0] ml);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) idle_for($urandom_range(0, gap_max));
    end
    burst_left--;
    start       <= 1'b1;
    req_type    <= rq;
    width_code  <= wc;
    put_value   <= pv;
    modifiers   <= mods;
    seek_target <= tgt;
    max_len     <= ml;
    do @(posedge clk); while (busy);
    sb.note_request(rq, wc, pv, mods, tgt, ml);
    sent++;
  endtask

  task automatic put_field(logic [2:0] wc, logic [63:0] v, logic [4:0] mods);
    issue(REQ_PUT, wc, v, mods, CUR_W'($urandom), WIN_W'($urandom));
  endtask

  task automatic get_field(logic [2:0] wc, logic [4:0] mods);
    issue(REQ_GET, wc, rand64(), mods, CUR_W'($urandom), WIN_W'($urandom));
  endtask

  task automatic seek_to(int unsigned t);
    issue(REQ_SEEK, 3'($urandom), rand64(), 5'($urandom), CUR_W'(t), WIN_W'($urandom));
  endtask

  task automatic read_string(int unsigned ml, logic [4:0] mods);
    issue(REQ_STR, 3'($urandom), rand64(), mods, CUR_W'($urandom), WIN_W'(ml));
  endtask

  task automatic write_text(int unsigned len, bit nl);
    int unsigned left;
    logic [63:0] chunk;
    left = len;
    while (left >= 8) begin
      for (int i = 0; i < 8; i++) chunk[8*i +: 8] = text_byte();
      put_field(3'd4, chunk, {2'($urandom_range(0, 3)), 3'b000});
      left -= 8;
    end
    while (left > 0) begin
      put_field(3'd0, {56'(rand64()), text_byte()}, {2'($urandom_range(0, 3)), 3'b000});
      left--;
    end
    put_field(3'd0, {56'(rand64()), nl ? TERM_NL : TERM_NUL},
              {2'($urandom_range(0, 3)), 3'b000});
  endtask

  task automatic field_record();
    logic [2:0] wcs [4];
    logic [4:0] ms [4];
    int unsigned base, cnt;
    base = pick_base();
    cnt = $urandom_range(1, 4);
    seek_to(base);
    for (int i = 0; i < cnt; i++) begin
      wcs[i] = 3'($urandom_range(0, 7));
      ms[i] = 5'($urandom);
      put_field(wcs[i], rand64(), ms[i]);
    end
    seek_to(base);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) < 7) get_field(wcs[i], ms[i]);
      else get_field(3'($urandom), 5'($urandom));
    end
  endtask

  task automatic string_record();
    int unsigned base, len, ml;
    bit nl;
    base = pick_base();
    len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 12) : $urandom_range(13, 62);
    nl = 1'($urandom_range(0, 1));
    seek_to(base);
    write_text(len, nl);
    seek_to(base);
    ml = ($urandom_range(0, 9) < 8) ? $urandom_range(len + 2, 127) : $urandom_range(0, len + 1);
    read_string(ml, {nl, 4'($urandom)});
    if ($urandom_range(0, 3) == 0) read_string($urandom_range(0, 127), 5'($urandom));
  endtask

  task automatic noise_burst();
    int unsigned tgt;
    for (int i = 0; i < 5; i++) begin
      tgt = ($urandom_range(0, 9) < 8) ? $urandom_range(0, BUF_BYTES) : $urandom_range(0, 8191);
      issue(req_t'($urandom_range(0, 3)), 3'($urandom), rand64(), 5'($urandom), CUR_W'(tgt),
            WIN_W'($urandom));
    end
  endtask

  initial begin
    int random_base, pick, choice;
    bit drained_mid;
    sb = new();
    rst         <= 1'b1;
    start       <= 1'b0;
    req_type    <= REQ_PUT;
    width_code  <= '0;
    put_value   <= '0;
    modifiers   <= '0;
    seek_target <= '0;
    max_len     <= '0;
    sent = 0;
    burst_left = 0;
    gap_max = 2;
    drained_mid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    get_field(3'd4, 5'b00000);
    seek_to(0);
    put_field(3'd4, 64'h0123_4567_89AB_CDEF, 5'b00000);
    seek_to(0);
    get_field(3'd4, 5'b01000);
    put_field(3'd7, 64'hFFFF_FFFF_FFFF_FFFF, 5'b10111);
    seek_to(8);
    get_field(3'd5, 5'b00111);
    put_field(3'd0, 64'h0000_0000_0000_0080, 5'b00100);
    put_field(3'd1, 64'h0000_0000_0000_0102, 5'b01001);
    put_field(3'd2, 64'h0000_0000_000A_0B0C, 5'b00010);
    put_field(3'd3, 64'h0000_0000_4142_0A00, 5'b00000);
    seek_to(22);
    read_string(10, 5'b10000);
    read_string(127, 5'b00000);
    read_string(0, 5'b00000);
    read_string(1, 5'b10000);
    seek_to(22);
    read_string(2, 5'b00000);
    seek_to(BUF_BYTES);
    put_field(3'd0, 64'h55, 5'b00000);
    seek_to(BUF_BYTES + 1);
    seek_to(8191);
    seek_to(BUF_BYTES - 8);
    put_field(3'd4, rand64(), 5'b01000);
    get_field(3'd0, 5'b00000);
    read_string(64, 5'b00000);

    random_base = sent;
    while (sent - random_base < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        choice = $urandom_range(0, 3);
        gap_max = (choice == 0) ? 0 : (choice == 1) ? 1 : (choice == 2) ? 3 : 8;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) field_record();
      else if (pick < 80) string_record();
      else noise_burst();
      if ((!drained_mid && sent - random_base > RANDOM_ITEMS / 2) ||
          $urandom_range(0, 19) == 0) begin
        drain();
        drained_mid = 1'b1;
      end
    end

    drain();
    repeat (150) @(posedge clk);
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d predicted results never arrived", sb.outstanding()));
    $display("Run covered %0d items: %0d puts, %0d gets, %0d seeks, %0d string reads.",
             sent, sb.req_seen[REQ_PUT], sb.req_seen[REQ_GET], sb.req_seen[REQ_SEEK],
             sb.req_seen[REQ_STR]);
    $display("It checked %0d results, found %0d strings and saw %0d mismatches.",
             sb.results_seen, sb.strings_found, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pfb_pkg.sv
hw/rtl/pfb_ram.sv
hw/rtl/packet_field_buffer_codec.sv
tb/sv/codec_scoreboard_pkg.sv
tb/sv/tb_top.sv
